[rtl/core/shell_command_lexer_assert.svh]
// ----------------------------------------------------------------------------
// Shell command lexer assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LEXER_ASSERT_SVH
`define SHELL_COMMAND_LEXER_ASSERT_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define SCL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("shell command lexer: assertion failed");

// Check a property on every clock edge, reset included.
`define SCL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("shell command lexer: reset assertion failed");

`else

`define SCL_ASSERT(label, clk, rstn, prop)
`define SCL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/core/scl_pkg.sv]
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants of the shell command lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

    // Word storage limit: a word keeps at most MAX_WORD-1 bytes
    localparam int MAX_WORD  = 4096;
    localparam int CNT_W     = $clog2(MAX_WORD);
    localparam int LEN_W     = 12;

    // Results per input byte and the result-group queue
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int GRP_DEPTH = 4;
    localparam int GRP_PTR_W = $clog2(GRP_DEPTH);

    localparam logic [CNT_W-1:0] WORD_LIMIT = CNT_W'(MAX_WORD - 1);

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        KIND_WORD_BYTE = 4'd0,
        KIND_WORD_END  = 4'd1,
        KIND_SEMI      = 4'd2,
        KIND_PIPE      = 4'd3,
        KIND_OR        = 4'd4,
        KIND_AND       = 4'd5,
        KIND_BG        = 4'd6,
        KIND_OUT       = 4'd7,
        KIND_APPEND    = 4'd8,
        KIND_IN        = 4'd9,
        KIND_EOL       = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_TRUNC  = 2'd1,
        ERR_UNTERM = 2'd2
    } err_t;

    // Operator byte waiting for a possible second byte
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_PIPE = 2'd1,
        PEND_AMP  = 2'd2,
        PEND_GT   = 2'd3
    } pend_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       word_byte;
        quote_t           quoting;
        logic             has_var;
        logic             has_glob;
        logic [LEN_W-1:0] word_length;
        err_t             error;
    } res_t;

    // All results caused by one input byte, in order
    typedef struct packed {
        logic [RES_IDX_W-1:0]    last_idx;
        res_t [MAX_RES-1:0]      res;
    } grp_t;

endpackage

`default_nettype wire

[rtl/core/scl_lexer.sv]
// ----------------------------------------------------------------------------
// scl_lexer
// Input register, tokenizer state and the single-pass next-state logic that
// turns one byte into a group of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_lexer
    import scl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_ch,
    input  wire logic       in_line_end,
    output logic            grp_valid,
    input  wire logic       grp_ready,
    output grp_t            grp
);

    localparam int NSLOT     = 6;
    localparam int SLOT_PEND = 0;
    localparam int SLOT_BYTE = 1;
    localparam int SLOT_WEND = 2;
    localparam int SLOT_OP   = 3;
    localparam int SLOT_UNT  = 4;
    localparam int SLOT_EOL  = 5;

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
               c == CH_VT || c == CH_FF;
    endfunction

    function automatic pend_t op_of(logic [7:0] c);
        pend_t p;
        p = PEND_NONE;
        if (c == CH_PIPE) p = PEND_PIPE;
        else if (c == CH_AMP) p = PEND_AMP;
        else if (c == CH_GT) p = PEND_GT;
        return p;
    endfunction

    function automatic kind_t single_kind(pend_t p);
        kind_t k;
        unique case (p)
            PEND_PIPE: k = KIND_PIPE;
            PEND_AMP:  k = KIND_BG;
            default:   k = KIND_OUT;
        endcase
        return k;
    endfunction

    function automatic kind_t double_kind(pend_t p);
        kind_t k;
        unique case (p)
            PEND_PIPE: k = KIND_OR;
            PEND_AMP:  k = KIND_AND;
            default:   k = KIND_APPEND;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] double_char(pend_t p);
        logic [7:0] c;
        unique case (p)
            PEND_PIPE: c = CH_PIPE;
            PEND_AMP:  c = CH_AMP;
            default:   c = CH_GT;
        endcase
        return c;
    endfunction

    function automatic res_t op_result(kind_t k);
        res_t r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic res_t word_end(quote_t q, logic v, logic g,
                                      logic [CNT_W-1:0] n, err_t e);
        res_t r;
        r             = '0;
        r.kind        = KIND_WORD_END;
        r.quoting     = q;
        r.has_var     = v;
        r.has_glob    = g;
        r.word_length = LEN_W'(n);
        r.error       = e;
        return r;
    endfunction

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_end_reg;

    // Tokenizer state
    logic             in_word_reg,  in_word_next;
    quote_t           quote_reg,    quote_next;
    logic             var_reg,      var_next;
    logic             glob_reg,     glob_next;
    logic             bs_reg,       bs_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             ovf_reg,      ovf_next;
    pend_t            pend_reg,     pend_next;

    res_t                 cand [NSLOT];
    logic [NSLOT-1:0]     cand_v;
    logic [RES_IDX_W:0]   res_cnt;
    res_t [MAX_RES-1:0]   res_pack;
    logic                 advance;

    // Work out next state and the candidate results for the held byte
    always_comb begin : lex_next
        logic   esc;
        logic   consumed;
        logic   do_store;
        logic   end_now;
        logic   start_word;
        quote_t start_quote;
        logic   start_var;
        logic   start_glob;
        pend_t  code;

        in_word_next = in_word_reg;
        quote_next   = quote_reg;
        var_next     = var_reg;
        glob_next    = glob_reg;
        bs_next      = bs_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        pend_next    = PEND_NONE;
        cand_v       = '0;
        for (int i = 0; i < NSLOT; i++) begin
            cand[i] = '0;
        end
        esc         = bs_reg;
        consumed    = 1'b0;
        do_store    = 1'b0;
        end_now     = 1'b0;
        start_word  = 1'b0;
        start_quote = QUOTE_NONE;
        start_var   = 1'b0;
        start_glob  = 1'b0;
        code        = op_of(in_ch_reg);

        // Resolve a held operator: double it or emit the single form
        if (pend_reg != PEND_NONE) begin
            cand_v[SLOT_PEND] = 1'b1;
            if (in_ch_reg == double_char(pend_reg)) begin
                cand[SLOT_PEND] = op_result(double_kind(pend_reg));
                consumed        = 1'b1;
            end else begin
                cand[SLOT_PEND] = op_result(single_kind(pend_reg));
            end
        end

        if (!consumed) begin
            if (!in_word_reg) begin
                // Between words
                priority if (is_ws(in_ch_reg)) begin
                    start_word = 1'b0;
                end else if (in_ch_reg == CH_SEMI) begin
                    cand_v[SLOT_OP] = 1'b1;
                    cand[SLOT_OP]   = op_result(KIND_SEMI);
                end else if (in_ch_reg == CH_LT) begin
                    cand_v[SLOT_OP] = 1'b1;
                    cand[SLOT_OP]   = op_result(KIND_IN);
                end else if (code != PEND_NONE) begin
                    if (in_end_reg) begin
                        cand_v[SLOT_OP] = 1'b1;
                        cand[SLOT_OP]   = op_result(single_kind(code));
                    end else begin
                        pend_next = code;
                    end
                end else if (in_ch_reg == CH_SQUOTE || in_ch_reg == CH_DQUOTE) begin
                    start_word  = 1'b1;
                    start_quote = (in_ch_reg == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                end else if (!in_end_reg) begin
                    start_word = 1'b1;
                    start_var  = (in_ch_reg == CH_DOLLAR);
                    start_glob = (in_ch_reg == CH_STAR || in_ch_reg == CH_QMARK);
                    do_store   = 1'b1;
                end else begin
                    // Drop a plain byte at line end
                    start_word = 1'b0;
                end
            end else if ((quote_reg == QUOTE_NONE && (in_end_reg || is_ws(in_ch_reg))) ||
                         (quote_reg == QUOTE_SINGLE && in_ch_reg == CH_SQUOTE) ||
                         (quote_reg == QUOTE_DOUBLE && in_ch_reg == CH_DQUOTE)) begin
                // Close the word
                end_now = 1'b1;
            end else if (quote_reg != QUOTE_SINGLE && in_ch_reg == CH_DOLLAR && !esc) begin
                var_next = 1'b1;
                do_store = 1'b1;
            end else if (quote_reg == QUOTE_NONE && !esc) begin
                // Unquoted word: operators split it
                priority if (in_ch_reg == CH_STAR || in_ch_reg == CH_QMARK) begin
                    glob_next = 1'b1;
                    do_store  = 1'b1;
                end else if (in_ch_reg == CH_SEMI) begin
                    end_now         = 1'b1;
                    cand_v[SLOT_OP] = 1'b1;
                    cand[SLOT_OP]   = op_result(KIND_SEMI);
                end else if (in_ch_reg == CH_LT) begin
                    end_now         = 1'b1;
                    cand_v[SLOT_OP] = 1'b1;
                    cand[SLOT_OP]   = op_result(KIND_IN);
                end else if (code != PEND_NONE) begin
                    end_now   = 1'b1;
                    pend_next = code;
                end else begin
                    do_store = 1'b1;
                end
            end else begin
                do_store = 1'b1;
            end
        end

        // Finish the current word
        if (end_now) begin
            cand_v[SLOT_WEND] = 1'b1;
            cand[SLOT_WEND]   = word_end(quote_reg, var_reg, glob_reg, count_reg,
                                         ovf_reg ? ERR_TRUNC : ERR_NONE);
            in_word_next = 1'b0;
            quote_next   = QUOTE_NONE;
            var_next     = 1'b0;
            glob_next    = 1'b0;
            bs_next      = 1'b0;
            count_next   = '0;
            ovf_next     = 1'b0;
        end

        // Open a new word
        if (start_word) begin
            in_word_next = 1'b1;
            quote_next   = start_quote;
            var_next     = start_var;
            glob_next    = start_glob;
            bs_next      = 1'b0;
            count_next   = '0;
            ovf_next     = 1'b0;
        end

        // Store the byte, or mark the word truncated
        if (do_store) begin
            if (count_next < WORD_LIMIT) begin
                cand_v[SLOT_BYTE]         = 1'b1;
                cand[SLOT_BYTE]           = op_result(KIND_WORD_BYTE);
                cand[SLOT_BYTE].word_byte = in_ch_reg;
                count_next                = count_next + 1'b1;
                bs_next                   = (in_ch_reg == CH_BSLASH);
            end else begin
                ovf_next = 1'b1;
            end
        end

        // Close the line: flag an open quote, emit end of line, reset
        if (in_end_reg) begin
            if (in_word_next) begin
                cand_v[SLOT_UNT] = 1'b1;
                cand[SLOT_UNT]   = word_end(quote_next, var_next, glob_next, count_next,
                                            ERR_UNTERM);
            end
            cand_v[SLOT_EOL] = 1'b1;
            cand[SLOT_EOL]   = op_result(KIND_EOL);
            in_word_next     = 1'b0;
            quote_next       = QUOTE_NONE;
            var_next         = 1'b0;
            glob_next        = 1'b0;
            bs_next          = 1'b0;
            count_next       = '0;
            ovf_next         = 1'b0;
            pend_next        = PEND_NONE;
        end
    end

    // Pack the valid candidates in order
    always_comb begin
        res_cnt  = '0;
        res_pack = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (cand_v[i] && res_cnt < (RES_IDX_W+1)'(MAX_RES)) begin
                res_pack[res_cnt[RES_IDX_W-1:0]] = cand[i];
                res_cnt                          = res_cnt + 1'b1;
            end
        end
    end

    assign grp_valid = in_valid_reg && (res_cnt != '0);
    assign grp       = '{last_idx: RES_IDX_W'(res_cnt - 1'b1), res: res_pack};

    // Advance when the group is taken, or when the byte gives no result
    assign advance  = in_valid_reg && (grp_ready || res_cnt == '0);
    assign in_ready = !in_valid_reg || advance;

    // Hold the accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_ch_reg  <= in_ch;
            in_end_reg <= in_line_end;
        end
    end

    // Update tokenizer state once per byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg <= 1'b0;
            quote_reg   <= QUOTE_NONE;
            var_reg     <= 1'b0;
            glob_reg    <= 1'b0;
            bs_reg      <= 1'b0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= PEND_NONE;
        end else if (advance) begin
            in_word_reg <= in_word_next;
            quote_reg   <= quote_next;
            var_reg     <= var_next;
            glob_reg    <= glob_next;
            bs_reg      <= bs_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/scl_grp_fifo.sv]
// ----------------------------------------------------------------------------
// scl_grp_fifo
// Small queue of result groups between the lexer and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_grp_fifo
    import scl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire grp_t push_grp,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output grp_t      pop_grp
);

    localparam int FILL_W = GRP_PTR_W + 1;

    grp_t                 mem_reg [GRP_DEPTH];
    logic [GRP_PTR_W-1:0] wr_ptr_reg;
    logic [GRP_PTR_W-1:0] rd_ptr_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = (fill_reg != FILL_W'(GRP_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_grp    = mem_reg[rd_ptr_reg];

    // Write the incoming group
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/scl_serializer.sv]
// ----------------------------------------------------------------------------
// scl_serializer
// Output register: holds one result group and hands out its results one
// transaction at a time, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_serializer
    import scl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic grp_valid,
    output logic      grp_ready,
    input  wire grp_t grp,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res,
    output logic      out_last
);

    logic                 busy_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    grp_t                 grp_reg;
    logic                 is_last;
    logic                 load;

    assign is_last   = (idx_reg == grp_reg.last_idx);
    assign grp_ready = !busy_reg || (out_ready && is_last);
    assign load      = grp_valid && grp_ready;

    assign out_valid = busy_reg;
    assign out_res   = grp_reg.res[idx_reg];
    assign out_last  = is_last;

    // Step through the group, load the next one after its final result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && out_ready) begin
            if (is_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp;
        end
    end

endmodule

`default_nettype wire

[rtl/core/shell_command_lexer.sv]
// ----------------------------------------------------------------------------
// shell_command_lexer
// Streaming tokenizer for one shell command line per line_end.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one byte of the command line per transaction; s_line_end marks
//   the line's last byte. m_* gives the results: word bytes, word ends with
//   quoting, flags, length and error, operators and an end-of-line token.
//   m_last marks the final result caused by one input byte.
// Path: the first result of a byte passes the input register, the group
//   queue and the output register before it is presented.
// Throughput: one byte per cycle while each byte gives at most one result
//   and m_ready is high; a byte's results leave one per output transaction,
//   and a four-group queue absorbs bursts. Bytes that give no result
//   (whitespace, held operators, opening quotes) are not queued.
// Reset: aresetn (synchronous, active low) empties the queue and the output
//   register and returns the tokenizer to the start of a line.
// Stall: while m_ready is low the output holds; the queue fills and then
//   s_ready drops until space returns.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_command_lexer_assert.svh"

module shell_command_lexer
    import scl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_line_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_kind,
    output logic [7:0]       m_word_byte,
    output logic [1:0]       m_quoting,
    output logic             m_has_var,
    output logic             m_has_glob,
    output logic [LEN_W-1:0] m_word_length,
    output logic [1:0]       m_error,
    output logic             m_last
);

    logic lex_grp_valid;
    logic lex_grp_ready;
    grp_t lex_grp;
    logic q_grp_valid;
    logic q_grp_ready;
    grp_t q_grp;
    res_t out_res;

    scl_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_ch       (s_ch),
        .in_line_end (s_line_end),
        .grp_valid   (lex_grp_valid),
        .grp_ready   (lex_grp_ready),
        .grp         (lex_grp)
    );

    scl_grp_fifo u_grp_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (lex_grp_valid),
        .push_ready (lex_grp_ready),
        .push_grp   (lex_grp),
        .pop_valid  (q_grp_valid),
        .pop_ready  (q_grp_ready),
        .pop_grp    (q_grp)
    );

    scl_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (q_grp_valid),
        .grp_ready (q_grp_ready),
        .grp       (q_grp),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res),
        .out_last  (m_last)
    );

    // Break the result out onto its ports
    assign m_kind        = out_res.kind;
    assign m_word_byte   = out_res.word_byte;
    assign m_quoting     = out_res.quoting;
    assign m_has_var     = out_res.has_var;
    assign m_has_glob    = out_res.has_glob;
    assign m_word_length = out_res.word_length;
    assign m_error       = out_res.error;

    // End of line is always the final result of its byte
    `SCL_ASSERT(a_eol_last, aclk, aresetn, (m_valid && m_kind == KIND_EOL) |-> m_last)

    // Only word ends carry word attributes
    `SCL_ASSERT(a_attr_word_end, aclk, aresetn,
        (m_valid && m_kind != KIND_WORD_END) |->
        (m_quoting == QUOTE_NONE && m_word_length == '0 && m_error == ERR_NONE &&
         !m_has_var && !m_has_glob))

    // An unterminated quote is followed by the end-of-line token
    `SCL_ASSERT(a_unterm_not_last, aclk, aresetn,
        (m_valid && m_kind == KIND_WORD_END && m_error == ERR_UNTERM) |-> !m_last)

    // Reset leaves no result pending anywhere
    `SCL_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> (!m_valid && !lex_grp_valid && !q_grp_valid))

endmodule

`default_nettype wire

[tb/sv/shell_command_lexer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_command_lexer_test
// Streams command-line bytes into the lexer and checks every result token
// against a cycle-free tokenizer model kept in this module. A directed set
// of lines comes first, then random lines under three idle/stall mixes.
// ----------------------------------------------------------------------------

module shell_command_lexer_test;
    import scl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 155;

    typedef struct {
        kind_t            kind;
        logic [7:0]       word_byte;
        quote_t           quoting;
        logic             has_var;
        logic             has_glob;
        logic [LEN_W-1:0] word_length;
        err_t             error;
        logic             last;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       line_end;
    } lex_item_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_ch;
    logic             s_line_end;
    logic             m_valid;
    logic             m_ready;
    logic [3:0]       m_kind;
    logic [7:0]       m_word_byte;
    logic [1:0]       m_quoting;
    logic             m_has_var;
    logic             m_has_glob;
    logic [LEN_W-1:0] m_word_length;
    logic [1:0]       m_error;
    logic             m_last;

    lex_item_t byte_feed[$];
    token_t    token_queue[$];
    token_t    step_toks[$];

    logic      drv_busy;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        mismatch_count;
    int        items_queued;
    int        cycle_count;

    // Tokenizer model state
    logic       lx_in_word;
    quote_t     lx_quote;
    logic       lx_var;
    logic       lx_glob;
    logic [7:0] lx_prev;
    int         lx_count;
    pend_t      lx_pend;
    logic       lx_ovf;

    shell_command_lexer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_line_end    (s_line_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_word_byte   (m_word_byte),
        .m_quoting     (m_quoting),
        .m_has_var     (m_has_var),
        .m_has_glob    (m_has_glob),
        .m_word_length (m_word_length),
        .m_error       (m_error),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------------
    function automatic void lex_emit(kind_t k, logic [7:0] b, quote_t q, logic v,
                                     logic g, int len, err_t e);
        token_t t;
        if (step_toks.size() >= MAX_RES) return;
        t.kind        = k;
        t.word_byte   = b;
        t.quoting     = q;
        t.has_var     = v;
        t.has_glob    = g;
        t.word_length = LEN_W'(len);
        t.error       = e;
        t.last        = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void lex_op(kind_t k);
        lex_emit(k, 8'h00, QUOTE_NONE, 1'b0, 1'b0, 0, ERR_NONE);
    endfunction

    function automatic void lex_clear_word();
        lx_in_word = 1'b0;
        lx_quote   = QUOTE_NONE;
        lx_var     = 1'b0;
        lx_glob    = 1'b0;
        lx_prev    = 8'h00;
        lx_count   = 0;
        lx_ovf     = 1'b0;
    endfunction

    function automatic void lex_end_word(err_t e);
        err_t code;
        code = e;
        if (code == ERR_NONE && lx_ovf) code = ERR_TRUNC;
        lex_emit(KIND_WORD_END, 8'h00, lx_quote, lx_var, lx_glob, lx_count, code);
        lex_clear_word();
    endfunction

    // Stream the byte while the word has room, else mark truncation
    function automatic void lex_store(logic [7:0] c);
        if (lx_count < MAX_WORD - 1) begin
            lex_emit(KIND_WORD_BYTE, c, QUOTE_NONE, 1'b0, 1'b0, 0, ERR_NONE);
            lx_count++;
            lx_prev = c;
        end else begin
            lx_ovf = 1'b1;
        end
    endfunction

    function automatic logic lex_is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
               c == CH_VT || c == CH_FF;
    endfunction

    function automatic pend_t lex_op_of(logic [7:0] c);
        if (c == CH_PIPE) return PEND_PIPE;
        if (c == CH_AMP) return PEND_AMP;
        if (c == CH_GT) return PEND_GT;
        return PEND_NONE;
    endfunction

    function automatic kind_t lex_single(pend_t p);
        if (p == PEND_PIPE) return KIND_PIPE;
        if (p == PEND_AMP) return KIND_BG;
        return KIND_OUT;
    endfunction

    function automatic kind_t lex_double(pend_t p);
        if (p == PEND_PIPE) return KIND_OR;
        if (p == PEND_AMP) return KIND_AND;
        return KIND_APPEND;
    endfunction

    // Hold an operator byte for lookahead unless the line ends here
    function automatic void lex_take_op(pend_t p, logic eol);
        if (eol) lex_op(lex_single(p));
        else lx_pend = p;
    endfunction

    function automatic void lex_process(logic [7:0] c, logic eol);
        logic esc;
        if (!lx_in_word) begin
            if (lex_is_space(c)) return;
            if (c == CH_SEMI) begin
                lex_op(KIND_SEMI);
                return;
            end
            if (c == CH_LT) begin
                lex_op(KIND_IN);
                return;
            end
            if (lex_op_of(c) != PEND_NONE) begin
                lex_take_op(lex_op_of(c), eol);
                return;
            end
            if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                lex_clear_word();
                lx_in_word = 1'b1;
                lx_quote   = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                return;
            end
            // a plain byte at line end starts nothing
            if (eol) return;
            lex_clear_word();
            lx_in_word = 1'b1;
            if (c == CH_DOLLAR) lx_var = 1'b1;
            else if (c == CH_STAR || c == CH_QMARK) lx_glob = 1'b1;
            lex_store(c);
            return;
        end
        // Close the word; the closing byte itself is dropped
        if ((lx_quote == QUOTE_NONE && (eol || lex_is_space(c))) ||
            (lx_quote == QUOTE_SINGLE && c == CH_SQUOTE) ||
            (lx_quote == QUOTE_DOUBLE && c == CH_DQUOTE)) begin
            lex_end_word(ERR_NONE);
            return;
        end
        esc = (lx_prev == CH_BSLASH);
        if (lx_quote != QUOTE_SINGLE && c == CH_DOLLAR && !esc) begin
            lx_var = 1'b1;
            lex_store(c);
        end else if (lx_quote == QUOTE_NONE && !esc) begin
            if (c == CH_STAR || c == CH_QMARK) begin
                lx_glob = 1'b1;
                lex_store(c);
            end else if (c == CH_SEMI) begin
                lex_end_word(ERR_NONE);
                lex_op(KIND_SEMI);
            end else if (c == CH_LT) begin
                lex_end_word(ERR_NONE);
                lex_op(KIND_IN);
            end else if (lex_op_of(c) != PEND_NONE) begin
                lex_end_word(ERR_NONE);
                lex_take_op(lex_op_of(c), eol);
            end else begin
                lex_store(c);
            end
        end else begin
            lex_store(c);
        end
    endfunction

    // Work out the tokens one accepted byte causes and queue them
    function automatic void lex_byte(logic [7:0] c, logic eol);
        pend_t      p;
        logic       consumed;
        logic [7:0] dbl;
        step_toks.delete();
        consumed = 1'b0;
        if (lx_pend != PEND_NONE) begin
            p       = lx_pend;
            lx_pend = PEND_NONE;
            case (p)
                PEND_PIPE: dbl = CH_PIPE;
                PEND_AMP:  dbl = CH_AMP;
                default:   dbl = CH_GT;
            endcase
            if (c == dbl) begin
                lex_op(lex_double(p));
                consumed = 1'b1;
            end else begin
                lex_op(lex_single(p));
            end
        end
        if (!consumed) lex_process(c, eol);
        if (eol) begin
            if (lx_in_word) lex_end_word(ERR_UNTERM);
            lex_op(KIND_EOL);
            lex_clear_word();
            lx_pend = PEND_NONE;
        end
        if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void feed_byte(logic [7:0] c, logic eol);
        lex_item_t item;
        item.ch       = c;
        item.line_end = eol;
        byte_feed.push_back(item);
        items_queued++;
    endfunction

    function automatic void feed_text(string s);
        for (int i = 0; i < s.len(); i++) feed_byte(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    // Mostly letters, with metacharacters, escapes and quotes mixed in
    function automatic logic [7:0] rand_word_byte();
        int r;
        r = $urandom_range(99);
        if (r < 58) return rand_letter();
        if (r < 66) return CH_DOLLAR;
        if (r < 71) return CH_STAR;
        if (r < 75) return CH_QMARK;
        if (r < 85) return CH_BSLASH;
        if (r < 87) return CH_SEMI;
        if (r < 89) return CH_PIPE;
        if (r < 91) return CH_AMP;
        if (r < 93) return CH_GT;
        if (r < 94) return CH_LT;
        if (r < 96) return CH_SQUOTE;
        if (r < 97) return CH_DQUOTE;
        return 8'($urandom_range(255));
    endfunction

    // Queue one random line: mostly words, quotes and operators, some noise
    function automatic void feed_random_line();
        logic [7:0] txt[$];
        int         ntok;
        int         len;
        if ($urandom_range(99) < 15) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) txt.push_back(8'($urandom_range(255)));
        end else begin
            ntok = $urandom_range(1, 6);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0 && $urandom_range(3) != 0) begin
                    txt.push_back(rand_space());
                    if ($urandom_range(3) == 0) txt.push_back(rand_space());
                end
                case ($urandom_range(9))
                    5, 6: begin
                        txt.push_back(($urandom_range(1) == 0) ? CH_SQUOTE : CH_DQUOTE);
                        len = $urandom_range(0, 6);
                        for (int i = 0; i < len; i++) txt.push_back(rand_word_byte());
                        // leave some quotes open
                        if ($urandom_range(4) != 0) txt.push_back(txt[txt.size() - len - 1]);
                    end
                    7, 8: begin
                        case ($urandom_range(7))
                            0: txt.push_back(CH_SEMI);
                            1: txt.push_back(CH_PIPE);
                            2: begin txt.push_back(CH_PIPE); txt.push_back(CH_PIPE); end
                            3: txt.push_back(CH_AMP);
                            4: begin txt.push_back(CH_AMP); txt.push_back(CH_AMP); end
                            5: txt.push_back(CH_GT);
                            6: begin txt.push_back(CH_GT); txt.push_back(CH_GT); end
                            default: txt.push_back(CH_LT);
                        endcase
                    end
                    9: begin
                        len = $urandom_range(1, 3);
                        for (int i = 0; i < len; i++) txt.push_back(8'($urandom_range(255)));
                    end
                    default: begin
                        len = $urandom_range(1, 8);
                        for (int i = 0; i < len; i++) txt.push_back(rand_word_byte());
                    end
                endcase
            end
            // the last byte is often lost, so pad half the lines
            if ($urandom_range(1) == 0) txt.push_back(rand_space());
        end
        foreach (txt[i]) feed_byte(txt[i], i == txt.size() - 1);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued bytes, randomly idle, randomly stall results
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        lex_item_t item;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (!drv_busy) begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    item = byte_feed.pop_front();
                    s_ch       <= item.ch;
                    s_line_end <= item.line_end;
                    s_valid    <= 1'b1;
                    drv_busy = 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each input transaction, check each result one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        token_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                lex_byte(s_ch, s_line_end);
                drv_busy = 1'b0;
            end
            if (m_valid && m_ready) begin
                if (token_queue.size() == 0) begin
                    $display("%0t: unexpected result kind %0d byte %0d", $time, m_kind,
                             m_word_byte);
                    mismatch_count++;
                end else begin
                    want = token_queue.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("word_byte", want.word_byte, m_word_byte);
                    check_field("quoting", want.quoting, m_quoting);
                    check_field("has_var", want.has_var, m_has_var);
                    check_field("has_glob", want.has_glob, m_has_glob);
                    check_field("word_length", want.word_length, m_word_length);
                    check_field("error", want.error, m_error);
                    check_field("last", want.last, m_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed lines, three random phases
    // ------------------------------------------------------------------------
    initial begin
        int target;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_ch           = 8'h00;
        s_line_end     = 1'b0;
        m_ready        = 1'b0;
        drv_busy       = 1'b0;
        tx_idle_pct    = 7;
        rx_idle_pct    = 61;
        mismatch_count = 0;
        items_queued   = 0;
        cycle_count    = 0;
        lex_clear_word();
        lx_pend = PEND_NONE;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every doubled operator, input and semicolon, a top byte dropped at line end
        feed_text("x||\t&&>><;\377");
        // a single-quoted dollar that sets no variable, then an unterminated double-quoted variable
        feed_text("'$'\"$*");
        // zero byte, escaped semicolon, glob, operator lost at line end
        feed_byte(8'h00, 1'b0);
        feed_text("\\;?|");
        // single operators and a held one resolved by a plain byte
        feed_text("|a&b>c>");

        for (int phase = 0; phase < 3; phase++) begin
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) feed_random_line();
            // hold new input until the whole phase has drained
            while (byte_feed.size() != 0 || drv_busy || token_queue.size() != 0)
                @(posedge aclk);
            if (phase == 0) begin
                tx_idle_pct = 61;
                rx_idle_pct = 7;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        end

        // let any stray result show up
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && token_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
